@@ rtl/core/ocbqos_pkg.sv @@
// Shared types and constants of the OCB QoS Data frame parser.
package ocbqos_pkg;

  localparam int HEADER_BYTES = 34;
  localparam int FCS_BYTES    = 4;
  localparam int QUEUE_DEPTH  = 4;

  localparam int POS_W      = 13;
  localparam int LEN_W      = POS_W + 1;
  localparam int MAX_LEN_W  = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int ADDR_W     = 48;

  localparam logic [POS_W-1:0]     POS_MAX       = {POS_W{1'b1}};
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 12'd1398;

  localparam logic [CFG_IDX_W-1:0] CFG_FCS_PRESENT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD_LEN = 1'b1;

  localparam logic [1:0] STAT_ACCEPTED    = 2'd0;
  localparam logic [1:0] STAT_INVALID_ARG = 2'd1;
  localparam logic [1:0] STAT_UNSUPPORTED = 2'd2;

  localparam logic RESULT_PAYLOAD = 1'b0;
  localparam logic RESULT_STATUS  = 1'b1;

  localparam logic [7:0] FC_QOS_DATA    = 8'h88;
  localparam logic [7:0] FC_FLAGS_MASK  = 8'hc7;
  localparam logic [7:0] BSSID_WILDCARD = 8'hff;
  localparam logic [7:0] FRAG_NUM_MASK  = 8'h0f;
  localparam logic [7:0] AMSDU_MASK     = 8'h80;

  localparam logic [7:0] LLC_SNAP_WORD [8] = '{8'haa, 8'haa, 8'h03, 8'h00,
                                               8'h00, 8'h00, 8'h89, 8'h47};

  typedef struct packed {
    logic              has_payload;
    logic [7:0]        payload_byte;
    logic              has_status;
    logic [1:0]        status;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] src;
  } entry_t;

endpackage

@@ rtl/core/ocbqos_front.sv @@
// Front end: header checks, address capture, FCS hold-back and status per frame.
module ocbqos_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ocbqos_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ocbqos_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                                accept,
  input  logic [7:0]                          rx_byte,
  input  logic                                end_of_frame,
  output logic                                entry_vld,
  output ocbqos_pkg::entry_t                  entry
);
  import ocbqos_pkg::*;

  logic                 fcs_r;
  logic [MAX_LEN_W-1:0] max_len_r;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic                 unsup_r, unsup_nxt;
  logic [ADDR_W-1:0]    dest_r, dest_nxt;
  logic [ADDR_W-1:0]    src_r, src_nxt;
  logic [7:0]           hold_r [FCS_BYTES];
  logic [7:0]           hold_nxt [FCS_BYTES];
  logic [2:0]           hold_cnt_r, hold_cnt_nxt;

  logic                 in_hdr;
  logic                 hdr_bad;
  logic [2:0]           llc_idx;
  logic                 has_pay;
  logic [7:0]           pay_byte;
  logic [LEN_W-1:0]     len;
  logic [LEN_W-1:0]     min_len;
  logic [LEN_W-1:0]     plen;
  logic [1:0]           status;

  assign in_hdr  = pos_r < POS_W'(HEADER_BYTES);
  assign llc_idx = 3'(pos_r - POS_W'(26));

  always_comb begin
    hdr_bad = 1'b0;
    if (pos_r == POS_W'(0)) begin
      hdr_bad = rx_byte != FC_QOS_DATA;
    end else if (pos_r == POS_W'(1)) begin
      hdr_bad = (rx_byte & FC_FLAGS_MASK) != 8'h00;
    end else if (pos_r >= POS_W'(16) && pos_r < POS_W'(22)) begin
      hdr_bad = rx_byte != BSSID_WILDCARD;
    end else if (pos_r == POS_W'(22)) begin
      hdr_bad = (rx_byte & FRAG_NUM_MASK) != 8'h00;
    end else if (pos_r == POS_W'(24)) begin
      hdr_bad = (rx_byte & AMSDU_MASK) != 8'h00;
    end else if (pos_r >= POS_W'(26) && pos_r < POS_W'(HEADER_BYTES)) begin
      hdr_bad = rx_byte != LLC_SNAP_WORD[llc_idx];
    end
  end

  always_comb begin
    unsup_nxt    = unsup_r | (in_hdr & hdr_bad);
    dest_nxt     = dest_r;
    src_nxt      = src_r;
    hold_nxt     = hold_r;
    hold_cnt_nxt = hold_cnt_r;
    has_pay      = 1'b0;
    pay_byte     = rx_byte;
    if (in_hdr) begin
      if (pos_r >= POS_W'(4) && pos_r < POS_W'(10)) begin
        dest_nxt = {dest_r[ADDR_W-9:0], rx_byte};
      end else if (pos_r >= POS_W'(10) && pos_r < POS_W'(16)) begin
        src_nxt = {src_r[ADDR_W-9:0], rx_byte};
      end
    end else if (fcs_r) begin
      if (hold_cnt_r[2]) begin
        pay_byte = hold_r[0];
        for (int i = 0; i < FCS_BYTES - 1; i++) begin
          hold_nxt[i] = hold_r[i+1];
        end
        hold_nxt[FCS_BYTES-1] = rx_byte;
        has_pay = (pos_r >= POS_W'(HEADER_BYTES + FCS_BYTES)) &&
                  ((pos_r - POS_W'(HEADER_BYTES + FCS_BYTES)) < {1'b0, max_len_r});
      end else begin
        hold_nxt[hold_cnt_r[1:0]] = rx_byte;
        hold_cnt_nxt = hold_cnt_r + 3'd1;
      end
    end else begin
      has_pay = (pos_r - POS_W'(HEADER_BYTES)) < {1'b0, max_len_r};
    end
    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);
  end

  always_comb begin
    len     = {1'b0, pos_r} + LEN_W'(1);
    min_len = fcs_r ? LEN_W'(HEADER_BYTES + FCS_BYTES) : LEN_W'(HEADER_BYTES);
    plen    = len - min_len;
    if (len < min_len) begin
      status = STAT_INVALID_ARG;
    end else if (unsup_nxt) begin
      status = STAT_UNSUPPORTED;
    end else if (plen == '0 || plen > {2'b00, max_len_r}) begin
      status = STAT_INVALID_ARG;
    end else begin
      status = STAT_ACCEPTED;
    end
  end

  assign entry_vld          = accept & (has_pay | end_of_frame);
  assign entry.has_payload  = has_pay;
  assign entry.payload_byte = pay_byte;
  assign entry.has_status   = end_of_frame;
  assign entry.status       = status;
  assign entry.dest         = dest_nxt;
  assign entry.src          = src_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcs_r      <= 1'b0;
      max_len_r  <= MAX_LEN_RESET;
      pos_r      <= '0;
      unsup_r    <= 1'b0;
      dest_r     <= '0;
      src_r      <= '0;
      hold_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FCS_PRESENT:     fcs_r     <= cfg_wdata[0];
          CFG_MAX_PAYLOAD_LEN: max_len_r <= cfg_wdata[MAX_LEN_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (end_of_frame) begin
          pos_r      <= '0;
          unsup_r    <= 1'b0;
          dest_r     <= '0;
          src_r      <= '0;
          hold_cnt_r <= '0;
        end else begin
          pos_r      <= pos_nxt;
          unsup_r    <= unsup_nxt;
          dest_r     <= dest_nxt;
          src_r      <= src_nxt;
          hold_cnt_r <= hold_cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= hold_nxt;
    end
  end

endmodule

@@ rtl/core/ocbqos_queue.sv @@
// Short queue of classified entries between the front end and the result stage.
module ocbqos_queue #(
  parameter int DEPTH = ocbqos_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  ocbqos_pkg::entry_t wr_entry,
  output logic               full,
  input  logic               rd_en,
  output ocbqos_pkg::entry_t rd_entry,
  output logic               empty
);
  import ocbqos_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic            do_wr, do_rd;

  assign full     = count_r == CNT_W'(DEPTH);
  assign empty    = count_r == '0;
  assign do_wr    = wr_en & ~full;
  assign do_rd    = rd_en & ~empty;
  assign rd_entry = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/ocbqos_back.sv @@
// Result stage: turns each queued entry into one or two results, one per pop.
module ocbqos_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ocbqos_pkg::entry_t              q_entry,
  input  logic                            q_empty,
  output logic                            q_pop,
  output logic                            empty,
  input  logic                            pop,
  output logic                            result_kind,
  output logic [7:0]                      payload_byte,
  output logic [1:0]                      frame_status,
  output logic [ocbqos_pkg::ADDR_W-1:0]   dest_address,
  output logic [ocbqos_pkg::ADDR_W-1:0]   src_address,
  output logic                            run_last
);
  import ocbqos_pkg::*;

  entry_t slot_r;
  logic   slot_vld_r;
  logic   pay_done_r;
  logic   cur_is_pay;
  logic   take;
  logic   last_pop;
  logic   zero_addr;

  assign cur_is_pay = slot_r.has_payload & ~pay_done_r;
  assign take       = slot_vld_r & pop;
  assign last_pop   = take & ~(cur_is_pay & slot_r.has_status);
  assign q_pop      = (~slot_vld_r | last_pop) & ~q_empty;

  assign zero_addr    = ~cur_is_pay & (slot_r.status != STAT_ACCEPTED);
  assign empty        = ~slot_vld_r;
  assign result_kind  = cur_is_pay ? RESULT_PAYLOAD : RESULT_STATUS;
  assign payload_byte = cur_is_pay ? slot_r.payload_byte : 8'h00;
  assign frame_status = cur_is_pay ? STAT_ACCEPTED : slot_r.status;
  assign dest_address = zero_addr ? '0 : slot_r.dest;
  assign src_address  = zero_addr ? '0 : slot_r.src;
  assign run_last     = ~(cur_is_pay & slot_r.has_status);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      slot_r <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= 1'b0;
      pay_done_r <= 1'b0;
    end else if (q_pop) begin
      slot_vld_r <= 1'b1;
      pay_done_r <= 1'b0;
    end else if (last_pop) begin
      slot_vld_r <= 1'b0;
    end else if (take) begin
      pay_done_r <= 1'b1;
    end
  end

endmodule

@@ rtl/core/ocb_qos_data_frame_parser_unit.sv @@
// Top level of the OCB QoS Data frame parser with LLC/SNAP header checks.
//
// The parser takes one frame byte per clock while full is low and gives a result for each
// forwarded payload byte and a status at the end of each frame, so one byte may cause two
// results. Each accepted byte is classified in the cycle it is taken and its results go into a
// queue of QUEUE_DEPTH entries; the output stage issues one result per clock, so full only rises
// when the consumer holds pop low or several end-of-frame bytes with payload come close
// together. Payload bytes are forwarded before the frame is judged and must be dropped unless
// the status is accepted. The user must write configuration through cfg_we, cfg_index and
// cfg_wdata only while the block is idle; the block does not enforce this.
module ocb_qos_data_frame_parser_unit #(
  parameter int QUEUE_DEPTH = ocbqos_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ocbqos_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ocbqos_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                              push,
  output logic                              full,
  input  logic [7:0]                        in_rx_byte,
  input  logic                              in_end_of_frame,
  output logic                              empty,
  input  logic                              pop,
  output logic                              out_result_kind,
  output logic [7:0]                        out_payload_byte,
  output logic [1:0]                        out_frame_status,
  output logic [ocbqos_pkg::ADDR_W-1:0]     out_dest_address,
  output logic [ocbqos_pkg::ADDR_W-1:0]     out_src_address,
  output logic                              out_run_last
);
  import ocbqos_pkg::*;

  logic   accept;
  logic   entry_vld;
  entry_t entry;
  entry_t q_entry;
  logic   q_empty;
  logic   q_pop;

  assign accept = push & ~full;

  ocbqos_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .accept       (accept),
    .rx_byte      (in_rx_byte),
    .end_of_frame (in_end_of_frame),
    .entry_vld    (entry_vld),
    .entry        (entry)
  );

  ocbqos_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (entry_vld),
    .wr_entry (entry),
    .full     (full),
    .rd_en    (q_pop),
    .rd_entry (q_entry),
    .empty    (q_empty)
  );

  ocbqos_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_entry      (q_entry),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .result_kind  (out_result_kind),
    .payload_byte (out_payload_byte),
    .frame_status (out_frame_status),
    .dest_address (out_dest_address),
    .src_address  (out_src_address),
    .run_last     (out_run_last)
  );

  // A payload result that is not the last of its request is always followed by its status.
  a_status_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && out_result_kind == RESULT_PAYLOAD && !out_run_last)
    |=> (!empty && out_result_kind == RESULT_STATUS && out_run_last))
    else $error("status result did not follow its payload result");

  // A rejected frame reports no addresses.
  a_reject_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_result_kind == RESULT_STATUS && out_frame_status != STAT_ACCEPTED)
    |-> (out_dest_address == '0 && out_src_address == '0))
    else $error("rejected frame carries addresses");

  // Payload results always carry the accepted status code.
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_result_kind == RESULT_PAYLOAD)
    |-> (out_frame_status == STAT_ACCEPTED))
    else $error("payload result carries a status");

  // Status results are always the last of their request.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_result_kind == RESULT_STATUS) |-> out_run_last)
    else $error("status result not marked last");

endmodule

@@ test/tb_ocb_qos_data_frame_parser_unit.sv @@
// Self-checking testbench for the OCB QoS Data frame parser: directed and random frames.
module tb_ocb_qos_data_frame_parser_unit;
  import ocbqos_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 4;
  localparam int RANDOM_BYTES = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int TIMEOUT      = 40_000_000;

  localparam logic [63:0] SNAP_WORD = 64'haaaa_0300_0000_8947;

  typedef struct packed {
    logic              kind;
    logic [7:0]        data;
    logic [1:0]        status;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] src;
    logic              last;
  } parse_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  in_end_of_frame = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic                  out_result_kind;
  logic [7:0]            out_payload_byte;
  logic [1:0]            out_frame_status;
  logic [ADDR_W-1:0]     out_dest_address;
  logic [ADDR_W-1:0]     out_src_address;
  logic                  out_run_last;

  // Predictor state and its copy of the configuration registers.
  logic                 fcs_on = 1'b0;
  logic [MAX_LEN_W-1:0] max_len = MAX_LEN_RESET;
  logic [POS_W-1:0]     frame_pos = '0;
  logic                 hdr_bad = 1'b0;
  logic [ADDR_W-1:0]    dst_cap = '0;
  logic [ADDR_W-1:0]    src_cap = '0;
  logic [7:0]           fcs_held [FCS_BYTES];
  int                   held_cnt = 0;

  parse_result_t expected_results [$];
  parse_result_t want;
  logic [7:0]    frame_q [$];

  int errors = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int results_checked = 0;
  int burst_left = 0;
  bit sender_gaps_on = 1'b1;
  int stall_left = 0;
  int stall_max = 0;
  int pop_cycle = 0;

  ocb_qos_data_frame_parser_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .push            (push),
    .full            (full),
    .in_rx_byte      (in_rx_byte),
    .in_end_of_frame (in_end_of_frame),
    .empty           (empty),
    .pop             (pop),
    .out_result_kind (out_result_kind),
    .out_payload_byte(out_payload_byte),
    .out_frame_status(out_frame_status),
    .out_dest_address(out_dest_address),
    .out_src_address (out_src_address),
    .out_run_last    (out_run_last)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  initial begin
    #(TIMEOUT);
    $display("simulation failed");
    $finish;
  end

  // Returns {mask, value}: a header byte is good when its masked bits equal the masked value.
  function automatic logic [15:0] header_rule(input int pos);
    if (pos == 0) return {8'hff, FC_QOS_DATA};
    if (pos == 1) return {FC_FLAGS_MASK, 8'h00};
    if (pos >= 16 && pos < 22) return {8'hff, BSSID_WILDCARD};
    if (pos == 22) return {FRAG_NUM_MASK, 8'h00};
    if (pos == 24) return {AMSDU_MASK, 8'h00};
    if (pos >= 26 && pos < HEADER_BYTES) return {8'hff, 8'(SNAP_WORD >> (8 * (33 - pos)))};
    return 16'h0000;
  endfunction

  function automatic parse_result_t make_result(input logic kind, input logic [7:0] data,
                                                input logic [1:0] status,
                                                input logic [ADDR_W-1:0] dest,
                                                input logic [ADDR_W-1:0] src);
    parse_result_t r;
    r.kind   = kind;
    r.data   = data;
    r.status = status;
    r.dest   = dest;
    r.src    = src;
    r.last   = 1'b0;
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic eof);
    parse_result_t outs [2];
    logic [15:0]   rule;
    logic [7:0]    oldest;
    logic [1:0]    st;
    int            p;
    int            len;
    int            extra;
    int            plen;
    int            n;
    p = frame_pos;
    n = 0;
    if (p < HEADER_BYTES) begin
      rule = header_rule(p);
      if ((b & rule[15:8]) != (rule[7:0] & rule[15:8])) hdr_bad = 1'b1;
      if (p >= 4 && p < 10) dst_cap = {dst_cap[ADDR_W-9:0], b};
      else if (p >= 10 && p < 16) src_cap = {src_cap[ADDR_W-9:0], b};
    end else if (fcs_on) begin
      if (held_cnt >= FCS_BYTES) begin
        oldest = fcs_held[0];
        for (int i = 0; i < FCS_BYTES - 1; i++) fcs_held[i] = fcs_held[i + 1];
        fcs_held[FCS_BYTES - 1] = b;
        if (p >= HEADER_BYTES + FCS_BYTES && p - (HEADER_BYTES + FCS_BYTES) < int'(max_len)) begin
          outs[n] = make_result(RESULT_PAYLOAD, oldest, STAT_ACCEPTED, dst_cap, src_cap);
          n++;
        end
      end else begin
        fcs_held[held_cnt] = b;
        held_cnt++;
      end
    end else if (p - HEADER_BYTES < int'(max_len)) begin
      outs[n] = make_result(RESULT_PAYLOAD, b, STAT_ACCEPTED, dst_cap, src_cap);
      n++;
    end
    if (frame_pos != POS_MAX) frame_pos++;
    if (eof) begin
      len = p + 1;
      extra = fcs_on ? FCS_BYTES : 0;
      if (len < HEADER_BYTES + extra) begin
        st = STAT_INVALID_ARG;
      end else if (hdr_bad) begin
        st = STAT_UNSUPPORTED;
      end else begin
        plen = len - HEADER_BYTES - extra;
        st = (plen == 0 || plen > int'(max_len)) ? STAT_INVALID_ARG : STAT_ACCEPTED;
      end
      if (st == STAT_ACCEPTED)
        outs[n] = make_result(RESULT_STATUS, 8'h00, st, dst_cap, src_cap);
      else
        outs[n] = make_result(RESULT_STATUS, 8'h00, st, '0, '0);
      n++;
      frame_pos = '0;
      hdr_bad = 1'b0;
      dst_cap = '0;
      src_cap = '0;
      held_cnt = 0;
    end
    for (int i = 0; i < n; i++) begin
      outs[i].last = (i == n - 1);
      expected_results.push_back(outs[i]);
    end
  endtask

  task automatic check_field(input string name, input logic [ADDR_W-1:0] exp_v,
                             input logic [ADDR_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // A request is taken at a rising edge with push high and full low; results likewise with pop.
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) predict_byte(in_rx_byte, in_end_of_frame);
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: kind %0d byte %0h status %0d",
                 out_result_kind, out_payload_byte, out_frame_status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", want.kind, out_result_kind);
          check_field("payload_byte", want.data, out_payload_byte);
          check_field("frame_status", want.status, out_frame_status);
          check_field("dest_address", want.dest, out_dest_address);
          check_field("src_address", want.src, out_src_address);
          check_field("run_last", want.last, out_run_last);
          results_checked++;
        end
      end
    end
  end

  always @(negedge clk) begin
    pop_cycle++;
    if (pop_cycle % 256 == 0) begin
      case ($urandom_range(0, 3))
        0, 1: stall_max = 0;
        2: stall_max = 3;
        default: stall_max = 12;
      endcase
    end
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if (stall_max > 0 && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, stall_max);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = sender_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk);
        push <= 1'b0;
        in_rx_byte <= 8'($urandom);
        in_end_of_frame <= 1'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    push <= 1'b1;
    in_rx_byte <= b;
    in_end_of_frame <= eof;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic send_range(input int from, input int upto);
    for (int i = from; i < upto; i++) begin
      send_byte(frame_q[i], i == frame_q.size() - 1);
      if (i == frame_q.size() - 1) frames_sent++;
    end
  endtask

  task automatic send_frame();
    send_range(0, frame_q.size());
  endtask

  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FCS_PRESENT) fcs_on = val[0];
    else max_len = val[MAX_LEN_W-1:0];
  endtask

  // Builds a well-formed frame for the current setting, optionally breaking one header check.
  task automatic build_frame(input int payload_len, input int break_at);
    logic [15:0] rule;
    logic [7:0]  b;
    logic [7:0]  flip;
    frame_q.delete();
    for (int i = 0; i < HEADER_BYTES; i++) begin
      rule = header_rule(i);
      b = (8'($urandom) & ~rule[15:8]) | (rule[7:0] & rule[15:8]);
      if (i == break_at) begin
        do flip = 8'($urandom) & rule[15:8]; while (flip == 8'h00);
        b = b ^ flip;
      end
      frame_q.push_back(b);
    end
    for (int i = 0; i < payload_len; i++) frame_q.push_back(8'($urandom));
    if (fcs_on) for (int i = 0; i < FCS_BYTES; i++) frame_q.push_back(8'($urandom));
  endtask

  task automatic send_truncated(input int len, input int break_at);
    build_frame(4, break_at);
    while (frame_q.size() > len) void'(frame_q.pop_back());
    send_frame();
  endtask

  function automatic int random_check_pos();
    int          pos;
    logic [15:0] rule;
    do begin
      pos = $urandom_range(0, HEADER_BYTES - 1);
      rule = header_rule(pos);
    end while (rule[15:8] == 8'h00);
    return pos;
  endfunction

  task automatic test_default_config();
    build_frame(1, -1);
    send_frame();
    build_frame(2, -1);
    for (int i = 4; i < 10; i++) frame_q[i] = 8'h00;
    for (int i = 10; i < 16; i++) frame_q[i] = 8'hff;
    frame_q[34] = 8'h00;
    frame_q[35] = 8'hff;
    send_frame();
  endtask

  task automatic test_header_faults();
    logic [15:0] rule;
    for (int pos = 0; pos < HEADER_BYTES; pos++) begin
      rule = header_rule(pos);
      if (rule[15:8] != 8'h00) begin
        build_frame(3, pos);
        send_frame();
      end
    end
  endtask

  task automatic test_short_frames();
    send_truncated(1, -1);
    send_truncated(20, 0);
    send_truncated(HEADER_BYTES - 1, -1);
    send_truncated(HEADER_BYTES, -1);
    wait_idle();
    write_reg(CFG_FCS_PRESENT, 12'd1);
    send_truncated(HEADER_BYTES, -1);
    send_truncated(HEADER_BYTES + FCS_BYTES - 1, -1);
    send_truncated(HEADER_BYTES + FCS_BYTES, -1);
    send_truncated(HEADER_BYTES + FCS_BYTES + 1, -1);
    wait_idle();
    write_reg(CFG_FCS_PRESENT, 12'd0);
  endtask

  task automatic test_payload_limits();
    wait_idle();
    write_reg(CFG_MAX_PAYLOAD_LEN, 12'd1);
    build_frame(1, -1);
    send_frame();
    build_frame(2, -1);
    send_frame();
    wait_idle();
    write_reg(CFG_FCS_PRESENT, 12'd1);
    build_frame(1, -1);
    send_frame();
    build_frame(3, -1);
    send_frame();
    wait_idle();
    write_reg(CFG_FCS_PRESENT, 12'd0);
    write_reg(CFG_MAX_PAYLOAD_LEN, 12'd40);
    build_frame(40, -1);
    send_frame();
    build_frame(41, -1);
    send_frame();
  endtask

  task automatic test_config_mid_frame();
    wait_idle();
    write_reg(CFG_FCS_PRESENT, 12'd1);
    build_frame(6, -1);
    send_range(0, HEADER_BYTES + 3);
    wait_idle();
    write_reg(CFG_FCS_PRESENT, 12'd0);
    send_range(HEADER_BYTES + 3, frame_q.size());
    build_frame(8, -1);
    send_range(0, HEADER_BYTES + 4);
    wait_idle();
    write_reg(CFG_FCS_PRESENT, 12'd1);
    send_range(HEADER_BYTES + 4, frame_q.size());
    wait_idle();
    write_reg(CFG_FCS_PRESENT, 12'd0);
  endtask

  task automatic test_random_traffic();
    int target;
    int plen;
    int extra;
    for (int phase = 0; phase < 5; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_reg(CFG_FCS_PRESENT, 12'd1);
          write_reg(CFG_MAX_PAYLOAD_LEN, 12'd1);
        end
        1: begin
          write_reg(CFG_FCS_PRESENT, 12'd0);
          write_reg(CFG_MAX_PAYLOAD_LEN, 12'd4095);
        end
        2: begin
          write_reg(CFG_FCS_PRESENT, 12'd1);
          write_reg(CFG_MAX_PAYLOAD_LEN, 12'($urandom_range(2, 40)));
        end
        3: begin
          write_reg(CFG_FCS_PRESENT, 12'd0);
          write_reg(CFG_MAX_PAYLOAD_LEN, 12'($urandom_range(2, 40)));
        end
        default: begin
          write_reg(CFG_FCS_PRESENT, 12'($urandom_range(0, 1)));
          write_reg(CFG_MAX_PAYLOAD_LEN, MAX_LEN_RESET);
        end
      endcase
      sender_gaps_on = (phase % 2 == 0);
      target = bytes_sent + RANDOM_BYTES / 5;
      while (bytes_sent < target) begin
        extra = fcs_on ? FCS_BYTES : 0;
        case ($urandom_range(0, 9))
          7: begin
            build_frame($urandom_range(0, 12), random_check_pos());
            send_frame();
          end
          8: send_truncated($urandom_range(1, HEADER_BYTES + extra), -1);
          9: begin
            frame_q.delete();
            repeat ($urandom_range(1, 64)) frame_q.push_back(8'($urandom));
            send_frame();
          end
          default: begin
            if (max_len <= 48 && $urandom_range(0, 3) == 0)
              plen = int'(max_len) + $urandom_range(0, 2) - 1;
            else
              plen = $urandom_range(1, 30);
            build_frame(plen, -1);
            send_frame();
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_config();
    test_header_faults();
    test_short_frames();
    test_payload_limits();
    test_config_mid_frame();
    test_random_traffic();
    wait_idle();
    $display("Sent %0d bytes in %0d frames and checked %0d results.",
             bytes_sent, frames_sent, results_checked);
    $display("Covered header faults, short and empty frames, FCS stripping, payload limits");
    $display("and register changes within a frame.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ ocb_qos_data_frame_parser_unit.f @@
rtl/core/ocbqos_pkg.sv
rtl/core/ocbqos_front.sv
rtl/core/ocbqos_queue.sv
rtl/core/ocbqos_back.sv
rtl/core/ocb_qos_data_frame_parser_unit.sv
test/tb_ocb_qos_data_frame_parser_unit.sv
